// ----- rtl/ftrh_pkg.sv -----
// Shared types and constants for the fat tree route hop generator.
package ftrh_pkg;

  // Field widths
  localparam int NPU_W  = 16;
  localparam int HALF_W = 6;
  localparam int ID_W   = 17;
  localparam int HH_W   = 11;
  localparam int LEAF_W = 11;
  localparam int IDX_W  = 3;
  localparam int HOPS   = 7;

  // Largest usable half radix
  localparam logic [HALF_W-1:0] HALF_MAX = 6'd32;

  // Divider: quotient bits resolved per stage, stages per division
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = NPU_W / DIV_STEPS;

  // Configuration register indexes
  localparam logic REG_HALF_K    = 1'b0;
  localparam logic REG_NPU_COUNT = 1'b1;

  // Item state carried down the divider pipeline
  typedef struct packed {
    logic [NPU_W-1:0]  src;
    logic [NPU_W-1:0]  dst;
    logic [HALF_W-1:0] h;
    logic [HH_W-1:0]   hh;
    logic [NPU_W-1:0]  npus;
    logic              bad;
    logic [NPU_W-1:0]  a_dq;
    logic [HALF_W-1:0] a_rem;
    logic [NPU_W-1:0]  b_dq;
    logic [HALF_W-1:0] b_rem;
    logic [LEAF_W-1:0] sl;
    logic [LEAF_W-1:0] dl;
  } stage_t;

  // Finished route waiting to be sent hop by hop
  typedef struct packed {
    logic [HOPS-1:0][ID_W-1:0] ids;
    logic [IDX_W-1:0]          last_idx;
    logic                      bad;
  } route_t;

endpackage

// ----- rtl/ftrh_div_stage.sv -----
// One divider pipeline stage: four restoring division steps on two lanes.
module ftrh_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  ftrh_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output ftrh_pkg::stage_t dn_data
);
  import ftrh_pkg::*;

  stage_t            nxt;
  logic [HALF_W:0]   a_r, b_r, dv;
  logic              a_ge, b_ge;
  logic [HALF_W:0]   a_sub, b_sub;

  // Resolve DIV_STEPS quotient bits, MSB first, for source and destination
  always_comb begin
    nxt = up_data;
    dv  = {1'b0, up_data.h};
    a_r = '0;
    b_r = '0;
    a_ge = 1'b0;
    b_ge = 1'b0;
    a_sub = '0;
    b_sub = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      a_r   = {nxt.a_rem, nxt.a_dq[NPU_W-1]};
      a_ge  = a_r >= dv;
      a_sub = a_r - dv;
      nxt.a_rem = a_ge ? a_sub[HALF_W-1:0] : a_r[HALF_W-1:0];
      nxt.a_dq  = {nxt.a_dq[NPU_W-2:0], a_ge};
      b_r   = {nxt.b_rem, nxt.b_dq[NPU_W-1]};
      b_ge  = b_r >= dv;
      b_sub = b_r - dv;
      nxt.b_rem = b_ge ? b_sub[HALF_W-1:0] : b_r[HALF_W-1:0];
      nxt.b_dq  = {nxt.b_dq[NPU_W-2:0], b_ge};
    end
  end

  // Advance when empty or when downstream takes the held beat
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

`ifndef ASSERT_OFF
  // Partial remainders always stay below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> (dn_data.a_rem < dn_data.h) && (dn_data.b_rem < dn_data.h))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ----- rtl/ftrh_route.sv -----
// Route stage: turns leaf, pod and slot numbers into the device id of every hop.
module ftrh_route (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  ftrh_pkg::stage_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output ftrh_pkg::route_t dn_data
);
  import ftrh_pkg::*;

  route_t                 nxt;
  logic [HALF_W-1:0]      sp, dp, ss, ds;
  logic [2*HALF_W-1:0]    sp_h, dp_h, ss_h;
  logic [ID_W-1:0]        leaf_base, spine_base, core_base;
  logic [ID_W-1:0]        src_id, dst_id, sleaf, dleaf, sspine, dspine, core;

  always_comb begin
    sp = up_data.a_dq[HALF_W-1:0];
    ss = up_data.a_rem;
    dp = up_data.b_dq[HALF_W-1:0];
    ds = up_data.b_rem;
    sp_h = sp * up_data.h;
    dp_h = dp * up_data.h;
    ss_h = ss * up_data.h;
    leaf_base  = {1'b0, up_data.npus};
    spine_base = leaf_base + {5'b0, up_data.hh, 1'b0};
    core_base  = spine_base + {6'b0, up_data.hh};
    src_id = {1'b0, up_data.src};
    dst_id = {1'b0, up_data.dst};
    sleaf  = leaf_base + {6'b0, up_data.sl};
    dleaf  = leaf_base + {6'b0, up_data.dl};
    sspine = spine_base + {5'b0, sp_h} + {11'b0, ss};
    dspine = spine_base + {5'b0, dp_h} + {11'b0, ss};
    core   = core_base + {5'b0, ss_h} + {11'b0, ds};

    // Pick the route shape: error, same leaf, same pod, or across the core
    nxt.ids = '0;
    nxt.bad = 1'b0;
    if (up_data.bad) begin
      nxt.bad      = 1'b1;
      nxt.last_idx = 3'd0;
    end else if (up_data.sl == up_data.dl) begin
      nxt.ids[0]   = src_id;
      nxt.ids[1]   = sleaf;
      nxt.ids[2]   = dst_id;
      nxt.last_idx = 3'd2;
    end else if (sp == dp) begin
      nxt.ids[0]   = src_id;
      nxt.ids[1]   = sleaf;
      nxt.ids[2]   = sspine;
      nxt.ids[3]   = dleaf;
      nxt.ids[4]   = dst_id;
      nxt.last_idx = 3'd4;
    end else begin
      nxt.ids[0]   = src_id;
      nxt.ids[1]   = sleaf;
      nxt.ids[2]   = sspine;
      nxt.ids[3]   = core;
      nxt.ids[4]   = dspine;
      nxt.ids[5]   = dleaf;
      nxt.ids[6]   = dst_id;
      nxt.last_idx = 3'd6;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule

// ----- rtl/ftrh_hop_ser.sv -----
// Hop serializer: holds one route and sends one hop beat per cycle while out_stall is low.
module ftrh_hop_ser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  ftrh_pkg::route_t         up_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ftrh_pkg::ID_W-1:0]  device_id,
  output logic [ftrh_pkg::IDX_W-1:0] hop_index,
  output logic                     last_hop,
  output logic                     bad_request
);
  import ftrh_pkg::*;

  route_t           route;
  logic [IDX_W-1:0] idx;
  logic             take;

  assign take        = out_valid && !out_stall;
  assign device_id   = route.ids[idx];
  assign hop_index   = idx;
  assign last_hop    = idx == route.last_idx;
  assign bad_request = route.bad;

  // Load the next route once the final beat of this one is taken
  assign up_ready = !out_valid || (take && last_hop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (up_ready) begin
      out_valid <= up_valid;
      idx       <= '0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      route <= up_data;
    end
  end

`ifndef ASSERT_OFF
  // An error result is a single beat
  bad_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_request |-> hop_index == 3'd0 && last_hop)
    else $error("error result is not a single beat");

  // Hops of one route go out in order with no gap
  hop_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_hop |=>
      out_valid && hop_index == $past(hop_index) + 3'd1)
    else $error("hop sequence broken");

  // Normal routes end after three, five or seven hops
  route_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_hop && !bad_request |->
      hop_index == 3'd2 || hop_index == 3'd4 || hop_index == 3'd6)
    else $error("route length is not 3, 5 or 7");
`endif

endmodule

// ----- rtl/fat_tree_route_hops.sv -----
// Top level of the fat tree route hop generator.
//
// Input channel (in_valid / in_stall) takes one request beat: src_npu and
// dest_npu. Output channel (out_valid / out_stall) returns one beat per hop:
// device_id, hop_index, last_hop and bad_request. A route is 3, 5 or 7 beats;
// a request with an endpoint not below npu_count gives one beat with
// bad_request set. The config port (cfg_we, cfg_index, cfg_data) writes
// half_k (index 0) and npu_count (index 1); write only while idle.
// Pipeline: one entry stage, eight divider stages (leaf, then pod and slot,
// four quotient bits per stage), one route stage and the hop serializer.
// The pipeline takes a new request every cycle until it fills; sustained
// throughput is set by the single hop beat per cycle on the output channel,
// so each route holds it for one beat per hop (one beat for an error). Reset
// empties the pipeline and loads half_k = 2, npu_count = 16. When out_stall
// is high the current hop holds and the stall backs up stage by stage to
// in_stall; nothing is lost.
module fat_tree_route_hops (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] src_npu,
  input  logic [15:0] dest_npu,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] device_id,
  output logic [2:0]  hop_index,
  output logic        last_hop,
  output logic        bad_request
);
  import ftrh_pkg::*;

  localparam int NDIV = 2 * DIV_STAGES;

  logic [HALF_W-1:0] half_k;
  logic [NPU_W-1:0]  npu_count;

  logic [HALF_W-1:0]   h_eff;
  logic [2*HALF_W-1:0] hh_full;
  stage_t              entry_next, entry;
  logic                entry_valid;

  stage_t div_in  [NDIV];
  stage_t div_out [NDIV];
  logic   div_in_valid  [NDIV];
  logic   div_in_ready  [NDIV];
  logic   div_out_valid [NDIV];
  logic   div_out_ready [NDIV];

  stage_t              mid;
  logic [NPU_W-1:0]    two_hh;

  logic   route_valid, route_ready;
  route_t route;
  logic   ser_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_k    <= 6'd2;
      npu_count <= 16'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_K:    half_k    <= cfg_data[HALF_W-1:0];
        REG_NPU_COUNT: npu_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry: clamp half_k, range check, seed both dividers with the endpoints
  always_comb begin
    if (half_k == '0) begin
      h_eff = 6'd1;
    end else if (half_k > HALF_MAX) begin
      h_eff = HALF_MAX;
    end else begin
      h_eff = half_k;
    end
    hh_full          = h_eff * h_eff;
    entry_next.src   = src_npu;
    entry_next.dst   = dest_npu;
    entry_next.h     = h_eff;
    entry_next.hh    = hh_full[HH_W-1:0];
    entry_next.npus  = npu_count;
    entry_next.bad   = (src_npu >= npu_count) || (dest_npu >= npu_count);
    entry_next.a_dq  = src_npu;
    entry_next.a_rem = '0;
    entry_next.b_dq  = dest_npu;
    entry_next.b_rem = '0;
    entry_next.sl    = '0;
    entry_next.dl    = '0;
  end

  assign in_stall = entry_valid && !div_in_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (!in_stall) begin
      entry_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      entry <= entry_next;
    end
  end

  // Between the two divisions: clamp leaves beyond capacity to leaf 0, then
  // divide the leaf numbers by h for pod and slot
  always_comb begin
    mid    = div_out[DIV_STAGES-1];
    two_hh = {4'b0, mid.hh, 1'b0};
    mid.sl = (mid.a_dq >= two_hh) ? '0 : mid.a_dq[LEAF_W-1:0];
    mid.dl = (mid.b_dq >= two_hh) ? '0 : mid.b_dq[LEAF_W-1:0];
    mid.a_dq  = {5'b0, mid.sl};
    mid.a_rem = '0;
    mid.b_dq  = {5'b0, mid.dl};
    mid.b_rem = '0;
  end

  // Divider pipeline
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    if (g == 0) begin : g_first
      assign div_in[g]       = entry;
      assign div_in_valid[g] = entry_valid;
    end else if (g == DIV_STAGES) begin : g_mid
      assign div_in[g]       = mid;
      assign div_in_valid[g] = div_out_valid[g-1];
    end else begin : g_mid_chain
      assign div_in[g]       = div_out[g-1];
      assign div_in_valid[g] = div_out_valid[g-1];
    end

    if (g == NDIV - 1) begin : g_last
      assign div_out_ready[g] = route_ready;
    end else begin : g_inner
      assign div_out_ready[g] = div_in_ready[g+1];
    end

    ftrh_div_stage u_div (
      .clk      (clk),
      .rst      (rst),
      .up_valid (div_in_valid[g]),
      .up_ready (div_in_ready[g]),
      .up_data  (div_in[g]),
      .dn_valid (div_out_valid[g]),
      .dn_ready (div_out_ready[g]),
      .dn_data  (div_out[g])
    );
  end

  ftrh_route u_route (
    .clk      (clk),
    .rst      (rst),
    .up_valid (div_out_valid[NDIV-1]),
    .up_ready (route_ready),
    .up_data  (div_out[NDIV-1]),
    .dn_valid (route_valid),
    .dn_ready (ser_ready),
    .dn_data  (route)
  );

  ftrh_hop_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (route_valid),
    .up_ready    (ser_ready),
    .up_data     (route),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .device_id   (device_id),
    .hop_index   (hop_index),
    .last_hop    (last_hop),
    .bad_request (bad_request)
  );

endmodule

// ----- verif/tb_fat_tree_route_hops.sv -----
// Self-checking testbench for the fat tree route hop generator.
module tb_fat_tree_route_hops;
  import ftrh_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 150;
  localparam int SETTLE      = 12;

  // One hop beat as seen on the result channel
  typedef struct packed {
    logic [ID_W-1:0]  dev;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             bad;
  } hop_t;

  // Route predictor plus the queue of hops still due from the block
  class route_scoreboard;
    hop_t             hops_due[$];
    logic [HALF_W-1:0] half_k_reg;
    logic [NPU_W-1:0]  npu_reg;

    function new();
      half_k_reg = 2;
      npu_reg    = 16;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == REG_HALF_K) begin
        half_k_reg = data[HALF_W-1:0];
      end else begin
        npu_reg = data[NPU_W-1:0];
      end
    endfunction

    // Clamp the radix register into the usable range
    function int eff_half();
      int h;
      h = half_k_reg;
      if (h == 0) h = 1;
      if (h > HALF_MAX) h = HALF_MAX;
      return h;
    endfunction

    function int npus();
      return npu_reg;
    endfunction

    // Endpoints past the tree's capacity fall back to leaf 0
    function longint unsigned leaf_for(longint unsigned n, longint unsigned h);
      if (n >= 2 * h * h * h) return 0;
      return n / h;
    endfunction

    function void add_hop(longint unsigned dev, int idx, bit last, bit bad);
      hop_t hp;
      hp.dev  = dev[ID_W-1:0];
      hp.idx  = idx[IDX_W-1:0];
      hp.last = last;
      hp.bad  = bad;
      hops_due.insert(hops_due.size(), hp);
    endfunction

    // Expand one request beat into its hop list
    function void note_request(logic [NPU_W-1:0] s, logic [NPU_W-1:0] d);
      longint unsigned h, n, leaf_base, spine_base, core_base;
      longint unsigned sl, dl, sp, dp, ss, ds;
      h          = eff_half();
      n          = npu_reg;
      leaf_base  = n;
      spine_base = n + 2 * h * h;
      core_base  = n + 3 * h * h;
      if (s >= n || d >= n) begin
        add_hop(0, 0, 1'b1, 1'b1);
        return;
      end
      sl = leaf_for(s, h);
      dl = leaf_for(d, h);
      add_hop(s, 0, 1'b0, 1'b0);
      add_hop(leaf_base + sl, 1, 1'b0, 1'b0);
      if (sl == dl) begin
        add_hop(d, 2, 1'b1, 1'b0);
        return;
      end
      sp = sl / h;
      dp = dl / h;
      ss = sl % h;
      ds = dl % h;
      add_hop(spine_base + sp * h + ss, 2, 1'b0, 1'b0);
      if (sp == dp) begin
        add_hop(leaf_base + dl, 3, 1'b0, 1'b0);
        add_hop(d, 4, 1'b1, 1'b0);
      end else begin
        add_hop(core_base + ss * h + ds, 3, 1'b0, 1'b0);
        add_hop(spine_base + dp * h + ss, 4, 1'b0, 1'b0);
        add_hop(leaf_base + dl, 5, 1'b0, 1'b0);
        add_hop(d, 6, 1'b1, 1'b0);
      end
    endfunction

    // Compare a hop beat with the oldest due hop; empty string means match
    function string check_hop(hop_t got);
      hop_t  want;
      string msg;
      if (hops_due.size() == 0)
        return $sformatf("unexpected hop beat device_id %0d hop_index %0d", got.dev, got.idx);
      want = hops_due.pop_front();
      msg  = "";
      if (got.dev !== want.dev)
        msg = {msg, $sformatf(" device_id %0d/%0d", got.dev, want.dev)};
      if (got.idx !== want.idx)
        msg = {msg, $sformatf(" hop_index %0d/%0d", got.idx, want.idx)};
      if (got.last !== want.last)
        msg = {msg, $sformatf(" last_hop %0b/%0b", got.last, want.last)};
      if (got.bad !== want.bad)
        msg = {msg, $sformatf(" bad_request %0b/%0b", got.bad, want.bad)};
      if (msg != "")
        return $sformatf("hop %0d (got/want):%s", want.idx, msg);
      return "";
    endfunction

    function int pending();
      return hops_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_HALF_K;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] src_npu = '0;
  logic [15:0] dest_npu = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] device_id;
  logic [2:0]  hop_index;
  logic        last_hop;
  logic        bad_request;

  route_scoreboard sb = new();
  int errors = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  fat_tree_route_hops u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .src_npu     (src_npu),
    .dest_npu    (dest_npu),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .device_id   (device_id),
    .hop_index   (hop_index),
    .last_hop    (last_hop),
    .bad_request (bad_request)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Sample both channels, check hop beats, and watch for a hang
  always @(posedge clk) begin : monitor
    hop_t  got;
    string msg;
    bit    moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.note_request(src_npu, dest_npu);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.dev  = device_id;
        got.idx  = hop_index;
        got.last = last_hop;
        got.bad  = bad_request;
        msg = sb.check_hop(got);
        if (msg != "") report_mismatch(msg);
        moved = 1'b1;
      end
    end
    if (rst || moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_fat_tree_route_hops: done, errors");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request beat, hold it until taken, then maybe idle a while
  task automatic send_req(logic [15:0] s, logic [15:0] d);
    in_valid <= 1'b1;
    src_npu  <= s;
    dest_npu <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every due hop has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Mostly valid routes biased toward shared leaves and pods, some noise
  task automatic random_phase(int count);
    int h, n, r, s, d;
    h = sb.eff_half();
    n = sb.npus();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      if (n == 0 || r == 0) begin
        s = $urandom_range(0, 65535);
        d = $urandom_range(0, 65535);
      end else if (r == 1) begin
        s = $urandom_range(0, n - 1);
        d = $urandom_range(n, 65535);
        if ($urandom_range(0, 1) == 1) begin
          r = s;
          s = d;
          d = r;
        end
      end else begin
        s = $urandom_range(0, n - 1);
        case (r % 3)
          0: d = (s / h) * h + $urandom_range(0, h - 1);
          1: d = (s / (h * h)) * (h * h) + $urandom_range(0, h * h - 1);
          default: d = $urandom_range(0, n - 1);
        endcase
        if (d >= n) d = $urandom_range(0, n - 1);
      end
      send_req(s[15:0], d[15:0]);
    end
  endtask

  initial begin : stimulus
    int h, cap;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: each route length, same endpoint, bad ids
    send_req(16'd0, 16'd1);
    send_req(16'd0, 16'd2);
    send_req(16'd0, 16'd15);
    send_req(16'd15, 16'd0);
    send_req(16'd5, 16'd5);
    send_req(16'd16, 16'd0);
    send_req(16'd3, 16'hFFFF);
    send_req(16'hFFFF, 16'hFFFF);
    drain();

    // More endpoints than the tree holds: the excess lands on leaf 0
    cfg_write(REG_NPU_COUNT, 16'd40);
    send_req(16'd20, 16'd0);
    send_req(16'd39, 16'd6);
    drain();

    // Zero radix behaves as one; junk above the register width is dropped
    cfg_write(REG_HALF_K, 16'hFFC0);
    cfg_write(REG_NPU_COUNT, 16'd10);
    send_req(16'd0, 16'd1);
    send_req(16'd9, 16'd0);
    drain();

    // Oversized radix saturates; largest endpoint count
    cfg_write(REG_HALF_K, 16'h003F);
    cfg_write(REG_NPU_COUNT, 16'hFFFF);
    send_req(16'd0, 16'd31);
    send_req(16'd0, 16'd32);
    send_req(16'd65534, 16'd0);
    send_req(16'd0, 16'd65534);
    send_req(16'hFFFF, 16'd0);
    send_req(16'd1023, 16'd1024);
    drain();

    // Single endpoint, then none at all
    cfg_write(REG_HALF_K, 16'd1);
    cfg_write(REG_NPU_COUNT, 16'd1);
    send_req(16'd0, 16'd0);
    send_req(16'd0, 16'd1);
    drain();
    cfg_write(REG_NPU_COUNT, 16'd0);
    send_req(16'd0, 16'd0);
    drain();

    // Random phases, each with its own tree shape
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: h = $urandom_range(1, 4);
        1: h = $urandom_range(5, 32);
        3: h = $urandom_range(0, 63);
        default: h = $urandom_range(1, 32);
      endcase
      cfg_write(REG_HALF_K, {10'($urandom_range(0, 1023)), h[5:0]});
      h   = sb.eff_half();
      cap = 2 * h * h * h;
      if (cap > 65535) cap = 65535;
      if (p % 2 == 0) begin
        cfg_write(REG_NPU_COUNT, 16'($urandom_range(1, cap)));
      end else begin
        cfg_write(REG_NPU_COUNT, 16'($urandom_range(1, 65535)));
      end
      if (p == 2) hold_req = 1'b1;
      if (p == 5) no_idle = 1'b1;
      random_phase(40);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_fat_tree_route_hops: done, clean");
    end else begin
      $display("tb_fat_tree_route_hops: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ftrh_pkg.sv
rtl/ftrh_div_stage.sv
rtl/ftrh_route.sv
rtl/ftrh_hop_ser.sv
rtl/fat_tree_route_hops.sv
verif/tb_fat_tree_route_hops.sv
